@@ design/rutd_pkg.sv @@
// ----------------------------------------------------------------------------
// rutd_pkg
// Shared constants for the runs up and down test.
// ----------------------------------------------------------------------------
package rutd_pkg;

  localparam int SAMPLE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int CRIT_BITS       = 10;
  localparam int CRIT_RESET      = 196;
  localparam int REJ_SCALE       = 10000;
  localparam int REJ_SCALE_BITS  = 14;
  localparam int Z_BITS          = 32;
  localparam int FRAC_SHIFT      = 32;
  localparam int ROOT_BITS       = 31;
  localparam int QUO_BITS        = 2 * ROOT_BITS;
  localparam int PRE_SHIFT       = QUO_BITS - FRAC_SHIFT;

endpackage

@@ design/rutd_mul.sv @@
// ----------------------------------------------------------------------------
// rutd_mul
// Shift-add multiplier, one multiplier bit per cycle, stops when the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module rutd_mul #(
  parameter int PW = 102,
  parameter int MB = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [PW-1:0] a_in,
  input  logic [MB-1:0] b_in,
  output logic          busy,
  output logic [PW-1:0] product
);

  logic [PW-1:0] acc;
  logic [PW-1:0] ma;
  logic [MB-1:0] mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mb <= '0;
    end else if (start) begin
      mb <= b_in;
    end else if (mb != '0) begin
      mb <= mb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ma  <= a_in;
    end else if (mb != '0) begin
      if (mb[0]) begin
        acc <= acc + ma;
      end
      ma <= ma << 1;
    end
  end

  assign busy    = (mb != '0);
  assign product = acc;

endmodule

@@ design/rutd_root.sv @@
// ----------------------------------------------------------------------------
// rutd_root
// Restoring divide of (tt << 32) by q, capped, then bitwise integer square
// root of the quotient. One bit per cycle in each phase.
// ----------------------------------------------------------------------------
module rutd_root
  import rutd_pkg::*;
#(
  parameter int QW = 66,
  parameter int TW = 83
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TW-1:0]        tt,
  input  logic [QW-1:0]        q,
  output logic                 busy,
  output logic [ROOT_BITS-1:0] mag
);

  localparam int CW  = (TW > QW + PRE_SHIFT) ? TW : QW + PRE_SHIFT;
  localparam int NW  = $clog2(QUO_BITS + 1);
  localparam int SRW = ROOT_BITS + 3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DIV  = 2'd1;
  localparam logic [1:0] PH_SQRT = 2'd2;

  logic [1:0]           phase;
  logic [NW-1:0]        cnt;
  logic [QW-1:0]        rem;
  logic [QUO_BITS-1:0]  dsr;
  logic [QUO_BITS-1:0]  quo;
  logic [QUO_BITS-1:0]  sx;
  logic [ROOT_BITS-1:0] root;
  logic [SRW-1:0]       srem;

  logic                 sat;
  logic [QW:0]          rem2;
  logic                 qbit;
  logic [QUO_BITS-1:0]  quo_next;
  logic [SRW-1:0]       srem2;
  logic [SRW-1:0]       trial;

  always_comb begin
    sat      = (CW'(tt) >= (CW'(q) << PRE_SHIFT));
    rem2     = {rem, dsr[QUO_BITS-1]};
    qbit     = (rem2 >= {1'b0, q});
    quo_next = {quo[QUO_BITS-2:0], qbit};
    srem2    = {srem[SRW-3:0], sx[QUO_BITS-1:QUO_BITS-2]};
    trial    = {1'b0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (start) begin
            if (sat) begin
              phase <= PH_SQRT;
              cnt   <= NW'(ROOT_BITS);
            end else begin
              phase <= PH_DIV;
              cnt   <= NW'(QUO_BITS);
            end
          end
        end
        PH_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == NW'(1)) begin
            phase <= PH_SQRT;
            cnt   <= NW'(ROOT_BITS);
          end
        end
        PH_SQRT: begin
          cnt <= cnt - 1'b1;
          if (cnt == NW'(1)) begin
            phase <= PH_IDLE;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (start) begin
          rem  <= QW'(tt >> PRE_SHIFT);
          dsr  <= {tt[PRE_SHIFT-1:0], FRAC_SHIFT'(0)};
          quo  <= '0;
          sx   <= '1;
          root <= '0;
          srem <= '0;
        end
      end
      PH_DIV: begin
        rem <= qbit ? QW'(rem2 - {1'b0, q}) : QW'(rem2);
        dsr <= dsr << 1;
        quo <= quo_next;
        if (cnt == NW'(1)) begin
          sx <= quo_next;
        end
      end
      PH_SQRT: begin
        sx <= sx << 2;
        if (srem2 >= trial) begin
          srem <= srem2 - trial;
          root <= {root[ROOT_BITS-2:0], 1'b1};
        end else begin
          srem <= srem2;
          root <= {root[ROOT_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign busy = (phase != PH_IDLE);
  assign mag  = root;

endmodule

@@ design/runs_up_down_randomness_test.sv @@
// ----------------------------------------------------------------------------
// runs_up_down_randomness_test
// Streaming runs up and down test with exact Z score and reject decision.
// ----------------------------------------------------------------------------
// Each sample item is taken while the block is idle. The item marked last
// closes the sequence and starts the statistic: a run of shift-add products
// on one multiplier (one multiplier bit per cycle, eight products, or only
// the first when the counts are degenerate), then a restoring divide (skipped
// when the quotient is capped) and a bitwise square root. Sample input stalls
// until the result is loaded into the output registers. A finished result may
// wait at the output while new samples are taken.
module runs_up_down_randomness_test
  import rutd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CRIT_BITS-1:0]   cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COUNT_BITS-1:0]  run_total,
  output logic [COUNT_BITS-1:0]  plus_total,
  output logic [COUNT_BITS-1:0]  minus_total,
  output logic signed [Z_BITS-1:0] z_score,
  output logic                   reject,
  output logic                   degenerate,
  output logic                   overflow
);

  localparam int C   = COUNT_BITS;
  localparam int NWD = C + 1;
  localparam int PWD = 2 * C + 1;
  localparam int QW  = 4 * C + 2;
  localparam int TW  = 5 * C + 3;
  localparam int C2W = 2 * CRIT_BITS;
  localparam int MB  = (PWD > C2W) ? PWD : C2W;
  localparam int PA  = TW + REJ_SCALE_BITS;
  localparam int PB  = QW + C2W;
  localparam int PW  = (PA > PB) ? PA : PB;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MP   = 4'd1;
  localparam logic [3:0] S_MNR  = 4'd2;
  localparam logic [3:0] S_MQ   = 4'd3;
  localparam logic [3:0] S_MD2  = 4'd4;
  localparam logic [3:0] S_MT   = 4'd5;
  localparam logic [3:0] S_MTK  = 4'd6;
  localparam logic [3:0] S_MC2  = 4'd7;
  localparam logic [3:0] S_MQC  = 4'd8;
  localparam logic [3:0] S_ROOT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [CRIT_BITS-1:0]   crit;
  logic                   have_previous;
  logic [SAMPLE_BITS-1:0] previous_sample;
  logic                   rising_now;
  logic [C-1:0]           plus_count;
  logic [C-1:0]           minus_count;
  logic [C-1:0]           run_count;
  logic                   overflowed;

  logic [3:0]             state;
  logic                   started;
  logic [C-1:0]           wa;
  logic [C-1:0]           wb;
  logic [C-1:0]           wr;
  logic                   wovf;
  logic                   wdegen;
  logic                   wneg;
  logic                   wrej;
  logic [PWD-1:0]         p;
  logic [PWD-1:0]         d;
  logic [QW-1:0]          q;
  logic [QW-1:0]          dsq;
  logic [TW-1:0]          tt;
  logic [PW-1:0]          tk;
  logic [C2W-1:0]         crit2;
  logic [ROOT_BITS-1:0]   wmag;

  logic                   in_acc;
  logic                   rise;
  logic                   first;
  logic                   sat_run;
  logic [C-1:0]           run_n;
  logic [C-1:0]           plus_n;
  logic [C-1:0]           minus_n;
  logic                   ovf_n;
  logic [NWD-1:0]         n;
  logic [C-1:0]           rm1;
  logic [PWD-1:0]         p_new;
  logic [PWD-1:0]         nr;
  logic                   mul_start;
  logic [PW-1:0]          mul_a;
  logic [MB-1:0]          mul_b;
  logic                   mul_busy;
  logic [PW-1:0]          mul_p;
  logic                   root_start;
  logic                   root_busy;
  logic [ROOT_BITS-1:0]   root_mag;
  logic                   load_out;
  logic [Z_BITS-1:0]      zsel;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    rise    = (previous_sample < sample);
    first   = (plus_count == '0) && (minus_count == '0);
    run_n   = run_count;
    plus_n  = plus_count;
    minus_n = minus_count;
    ovf_n   = overflowed;
    sat_run = 1'b0;
    if (have_previous) begin
      if (first) begin
        run_n = C'(1);
      end else if (rise != rising_now) begin
        sat_run = 1'b1;
        if (run_count == '1) begin
          ovf_n = 1'b1;
        end else begin
          run_n = run_count + 1'b1;
        end
      end
      if (rise) begin
        if (plus_count == '1) begin
          ovf_n = 1'b1;
        end else begin
          plus_n = plus_count + 1'b1;
        end
      end else begin
        if (minus_count == '1) begin
          ovf_n = 1'b1;
        end else begin
          minus_n = minus_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crit <= CRIT_BITS'(CRIT_RESET);
    end else if (cfg_we) begin
      crit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous   <= 1'b0;
      previous_sample <= '0;
      rising_now      <= 1'b0;
      plus_count      <= '0;
      minus_count     <= '0;
      run_count       <= '0;
      overflowed      <= 1'b0;
    end else if (in_acc) begin
      if (last) begin
        have_previous   <= 1'b0;
        previous_sample <= '0;
        rising_now      <= 1'b0;
        plus_count      <= '0;
        minus_count     <= '0;
        run_count       <= '0;
        overflowed      <= 1'b0;
      end else begin
        have_previous   <= 1'b1;
        previous_sample <= sample;
        if (have_previous && (first || sat_run)) begin
          rising_now <= rise;
        end
        plus_count  <= plus_n;
        minus_count <= minus_n;
        run_count   <= run_n;
        overflowed  <= ovf_n;
      end
    end
  end

  always_comb begin
    n     = NWD'(wa) + NWD'(wb);
    rm1   = (wr == '0) ? '0 : wr - 1'b1;
    p_new = PWD'(mul_p << 1);
    nr    = PWD'(mul_p);
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MP: begin
        mul_a = PW'(wa);
        mul_b = MB'(wb);
      end
      S_MNR: begin
        mul_a = PW'(n);
        mul_b = MB'(rm1);
      end
      S_MQ: begin
        mul_a = PW'(p);
        mul_b = MB'(p - PWD'(n));
      end
      S_MD2: begin
        mul_a = PW'(d);
        mul_b = MB'(d);
      end
      S_MT: begin
        mul_a = PW'(dsq);
        mul_b = MB'(n - 1'b1);
      end
      S_MTK: begin
        mul_a = PW'(tt);
        mul_b = MB'(REJ_SCALE);
      end
      S_MC2: begin
        mul_a = PW'(crit);
        mul_b = MB'(crit);
      end
      S_MQC: begin
        mul_a = PW'(q);
        mul_b = MB'(crit2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start  = !started && (state inside {S_MP, S_MNR, S_MQ, S_MD2, S_MT,
                                                 S_MTK, S_MC2, S_MQC});
  assign root_start = !started && (state == S_ROOT);
  assign load_out   = (state == S_DONE) && (!out_valid || !out_stall);

  rutd_mul #(
    .PW (PW),
    .MB (MB)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .busy    (mul_busy),
    .product (mul_p)
  );

  rutd_root #(
    .QW (QW),
    .TW (TW)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .tt    (tt),
    .q     (q),
    .busy  (root_busy),
    .mag   (root_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      started <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          started <= 1'b0;
          if (in_acc && last) begin
            state <= S_MP;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (!started) begin
            started <= 1'b1;
          end else if (!root_busy) begin
            started <= 1'b0;
            state   <= S_DONE;
          end
        end
        default: begin
          if (!started) begin
            started <= 1'b1;
          end else if (!mul_busy) begin
            started <= 1'b0;
            case (state)
              S_MP: begin
                if ((n >= NWD'(2)) && (p_new > PWD'(n))) begin
                  state <= S_MNR;
                end else begin
                  state <= S_DONE;
                end
              end
              S_MNR:   state <= S_MQ;
              S_MQ:    state <= S_MD2;
              S_MD2:   state <= S_MT;
              S_MT:    state <= S_MTK;
              S_MTK:   state <= S_MC2;
              S_MC2:   state <= S_MQC;
              S_MQC:   state <= S_ROOT;
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      wa     <= plus_n;
      wb     <= minus_n;
      wr     <= run_n;
      wovf   <= ovf_n;
      wdegen <= 1'b1;
      wneg   <= 1'b0;
      wrej   <= 1'b0;
      wmag   <= '0;
    end
    if (started && !mul_busy) begin
      case (state)
        S_MP: begin
          p      <= p_new;
          wdegen <= !((n >= NWD'(2)) && (p_new > PWD'(n)));
        end
        S_MNR: begin
          if (nr >= p) begin
            d    <= nr - p;
            wneg <= 1'b0;
          end else begin
            d    <= p - nr;
            wneg <= 1'b1;
          end
        end
        S_MQ:  q     <= QW'(mul_p);
        S_MD2: dsq   <= QW'(mul_p);
        S_MT:  tt    <= TW'(mul_p);
        S_MTK: tk    <= mul_p;
        S_MC2: crit2 <= C2W'(mul_p);
        S_MQC: wrej  <= (tk > mul_p);
        default: ;
      endcase
    end
    if ((state == S_ROOT) && started && !root_busy) begin
      wmag <= root_mag;
    end
  end

  assign zsel = wneg ? (Z_BITS'(0) - Z_BITS'(wmag)) : Z_BITS'(wmag);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      run_total   <= wr;
      plus_total  <= wa;
      minus_total <= wb;
      z_score     <= wdegen ? '0 : zsel;
      reject      <= wdegen ? 1'b0 : wrej;
      degenerate  <= wdegen;
      overflow    <= wovf;
    end
  end

endmodule

@@ test/tb_runs_up_down_randomness_test.sv @@
// ----------------------------------------------------------------------------
// tb_runs_up_down_randomness_test
// Self-checking bench for the streaming runs up and down test.
// ----------------------------------------------------------------------------
// Sample sequences are queued and driven into the block with random idle
// cycles on both sides. Each accepted item updates a local run and count
// tracker. On the last item of a sequence, the expected statistic is worked
// out with wide integer math: exact Z in Q16.16, reject, degenerate and
// overflow flags. Results from the block are checked in order against these
// expectations.
// ----------------------------------------------------------------------------
module tb_runs_up_down_randomness_test;
  import rutd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct {
    logic [15:0] runs;
    logic [15:0] plus;
    logic [15:0] minus;
    logic [31:0] z;
    logic        rej;
    logic        degen;
    logic        ovf;
  } run_stat_t;

  logic clk, rst;
  logic cfg_we;
  logic [CRIT_BITS-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [31:0] sample;
  logic last;
  logic out_valid, out_stall;
  logic [15:0] run_total, plus_total, minus_total;
  logic signed [31:0] z_score;
  logic reject, degenerate, overflow;

  runs_up_down_randomness_test dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .run_total(run_total),
    .plus_total(plus_total), .minus_total(minus_total), .z_score(z_score),
    .reject(reject), .degenerate(degenerate), .overflow(overflow)
  );

  sample_item_t pending_q[$];
  run_stat_t    stat_q[$];
  int unsigned  queued_cnt, accepted_cnt, result_cnt, seq_cnt, error_cnt;
  int unsigned  send_idle_pct, recv_idle_pct;
  int unsigned  hold_reqs, hold_done, hold_left;
  bit           send_pause;

  // local copy of the sequence tracker
  logic [9:0]  crit;
  bit          have_prev, rising;
  logic [31:0] prev_sample;
  logic [15:0] plus_cnt, minus_cnt, run_cnt;
  bit          ovf_seen;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [15:0] bump(logic [15:0] v);
    if (v == 16'hFFFF) begin
      ovf_seen = 1'b1;
      return v;
    end
    return v + 16'd1;
  endfunction

  task automatic track_sample(logic [31:0] s, logic l);
    logic [191:0] a, b, n, p, r, nr, d, q, rhs, t, c, mag;
    bit rise, neg;
    run_stat_t e;
    if (have_prev) begin
      rise = prev_sample < s;
      if (plus_cnt == 0 && minus_cnt == 0) begin
        run_cnt = bump(16'd0);
        rising = rise;
      end else if (rise != rising) begin
        run_cnt = bump(run_cnt);
        rising = rise;
      end
      if (rise) plus_cnt = bump(plus_cnt);
      else minus_cnt = bump(minus_cnt);
    end
    prev_sample = s;
    have_prev = 1'b1;
    if (!l) return;
    a = plus_cnt; b = minus_cnt; r = run_cnt;
    n = a + b;
    p = 2 * a * b;
    e.runs = run_cnt; e.plus = plus_cnt; e.minus = minus_cnt;
    e.z = '0; e.rej = 1'b0; e.degen = 1'b1; e.ovf = ovf_seen;
    if (n >= 2 && p > n) begin
      e.degen = 1'b0;
      nr = n * ((r > 0) ? r - 1 : 0);
      neg = nr < p;
      d = neg ? p - nr : nr - p;
      q = p * (p - n);
      t = d * d * (n - 1);
      rhs = t << 32;
      mag = 0;
      for (int i = 30; i >= 0; i--) begin
        c = mag | (192'd1 << i);
        if (q * c * c <= rhs) mag = c;
      end
      e.rej = (t * 10000) > (q * crit * crit);
      e.z = neg ? -mag[31:0] : mag[31:0];
    end
    stat_q.push_back(e);
    have_prev = 0; rising = 0; prev_sample = 0;
    plus_cnt = 0; minus_cnt = 0; run_cnt = 0; ovf_seen = 0;
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("ERROR result %0d: %s got %0h expected %0h", result_cnt, field, got, want);
    error_cnt++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sample <= '0;
      last <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_sample(sample, last);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && !send_pause && $urandom_range(99) >= send_idle_pct) begin
          sample <= pending_q[0].sample;
          last <= pending_q[0].last;
          void'(pending_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_done != hold_reqs) begin
      hold_done <= hold_reqs;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    run_stat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (stat_q.size() == 0) begin
        $display("ERROR unexpected result run_total=%0d", run_total);
        error_cnt++;
      end else begin
        e = stat_q.pop_front();
        if (run_total !== e.runs) report_mismatch("run_total", run_total, e.runs);
        if (plus_total !== e.plus) report_mismatch("plus_total", plus_total, e.plus);
        if (minus_total !== e.minus) report_mismatch("minus_total", minus_total, e.minus);
        if (z_score !== e.z) report_mismatch("z_score", z_score, e.z);
        if (reject !== e.rej) report_mismatch("reject", reject, e.rej);
        if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
        if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
      end
      result_cnt++;
    end
  end

  task automatic push_item(logic [31:0] s, logic l);
    sample_item_t it;
    it.sample = s;
    it.last = l;
    pending_q.push_back(it);
    queued_cnt++;
    if (l) seq_cnt++;
  endtask

  // shape: 0 random, 1 tiny range, 2 rising, 3 falling, 4 zigzag
  task automatic push_seq(int len, int shape);
    logic [31:0] v;
    v = $urandom;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: v = $urandom;
        1: v = $urandom_range(3);
        2: v = v + $urandom_range(1, 1000);
        3: v = v - $urandom_range(0, 1000);
        default: v = (i % 2) ? 32'hFFFF_FFFF - $urandom_range(50) : $urandom_range(50);
      endcase
      push_item(v, i == len - 1);
    end
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && accepted_cnt == queued_cnt && stat_q.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_crit(logic [9:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    crit = v;
  endtask

  task automatic push_random(int items);
    int got, len;
    got = 0;
    while (got < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
      push_seq(len, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      got += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    crit = CRIT_RESET;
    send_idle_pct = 10;
    recv_idle_pct = 47;
    send_pause = 0;
    hold_reqs = 0;
    {have_prev, rising, ovf_seen} = '0;
    prev_sample = '0;
    {plus_cnt, minus_cnt, run_cnt} = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset critical value
    push_item(32'h0, 1'b1);                       // no comparison
    push_item(32'h0, 1'b0); push_item(32'hFFFF_FFFF, 1'b1);  // one comparison
    push_item(32'h5, 1'b0); push_item(32'h9, 1'b0); push_item(32'h2, 1'b1); // P equals N
    push_seq(6, 1);
    for (int i = 0; i < 5; i++) push_item(32'h7, i == 4);    // all ties
    push_seq(8, 2);                               // no minus
    push_seq(12, 4);                              // many runs
    push_seq(10, 3);
    drain();

    write_crit(10'd1);
    push_seq(20, 4);
    push_seq(20, 2);
    push_random(350);
    hold_reqs++;
    push_random(100);
    drain();

    send_idle_pct = 47;
    recv_idle_pct = 10;
    write_crit(10'd999);
    push_seq(60, 4);
    push_random(200);
    wait (pending_q.size() == 0 && accepted_cnt == queued_cnt);
    send_pause = 1;
    push_random(250);
    wait (stat_q.size() == 0);
    send_pause = 0;
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_crit(10'($urandom_range(1, 999)));
    push_random(500);
    drain();

    $display("Covered %0d samples in %0d sequences, %0d results checked,",
             accepted_cnt, seq_cnt, result_cnt);
    $display("critical values 196, 1, 999 and random, long output hold and sender pause.");
    if (error_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
